// ===== design/b64d_pkg.sv =====
// Shared types, constants and the character classifier of the base64 stream decoder.
`default_nettype none

package b64d_pkg;

	// Width of the saturating byte counter.
	localparam int COUNT_BITS = 24;
	localparam int TOTAL_W    = 24;

	// Depth of the queue between the front and back parts.
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	// Class codes returned by the classifier.
	localparam logic [7:0] CODE_WS   = 8'hE0;
	localparam logic [7:0] CODE_LF   = 8'hF0;
	localparam logic [7:0] CODE_CR   = 8'hF1;
	localparam logic [7:0] CODE_DASH = 8'hF2;
	localparam logic [7:0] CODE_BAD  = 8'hFF;
	localparam logic [7:0] JUNK_MASK = 8'h13;
	localparam logic [7:0] JUNK_CODE = 8'hF3;
	localparam logic [7:0] CODE_PLUS = 8'h3E;
	localparam logic [7:0] CODE_SLSH = 8'h3F;
	localparam logic [7:0] CHAR_PAD  = 8'h3D;

	// One queue entry: the results caused by one input item.
	typedef struct packed {
		logic [2:0][7:0]      bytes;   // bytes[0] goes out first
		logic [1:0]           nbytes;  // 0 to 3 decoded bytes
		logic                 fin;     // entry closes the string
		logic                 bad;     // final status, valid with fin
		logic [TOTAL_W-1:0]   total;   // final byte count, valid with fin
	} b64d_entry_t;

	// Maps a character byte to its sextet value or a class code.
	function automatic logic [7:0] sextet_of(input logic [7:0] c);
		logic [7:0] r;
		r = CODE_BAD;
		if (c >= 8'h41 && c <= 8'h5A) r = c - 8'h41;
		else if (c >= 8'h61 && c <= 8'h7A) r = c - 8'h61 + 8'd26;
		else if (c >= 8'h30 && c <= 8'h39) r = c - 8'h30 + 8'd52;
		else if (c == 8'h2B) r = CODE_PLUS;
		else if (c == 8'h2F) r = CODE_SLSH;
		else if (c == 8'h09 || c == 8'h20) r = CODE_WS;
		else if (c == 8'h0A) r = CODE_LF;
		else if (c == 8'h0D) r = CODE_CR;
		else if (c == 8'h2D) r = CODE_DASH;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/b64d_front.sv =====
// Front part: classifies each character, tracks the string state and forms queue entries.
`default_nettype none

module b64d_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [7:0]        char_code,
	input  wire logic              final_char,
	output logic                   push,
	output b64d_pkg::b64d_entry_t  entry
);
	import b64d_pkg::*;

	logic                  lead_q, lead_n;
	logic [1:0]            gp_q, gp_n;
	logic [17:0]           hold_q, hold_n;
	logic                  pad_q, pad_n;
	logic                  err_q, err_n;
	logic [1:0]            kc_q, kc_n;
	logic                  ka_q, ka_n;
	logic [1:0]            hj_q, hj_n;
	logic                  hja_q, hja_n;
	logic [COUNT_BITS-1:0] cnt_q, cnt_n;

	logic [7:0]            code;
	logic                  is_junk;
	logic [1:0]            nb;
	logic [2:0][7:0]       bytes;
	logic [23:0]           word;
	logic [COUNT_BITS+1:0] sum;
	logic                  bad;

	// Classification of the incoming character.
	assign code    = char_code[7] ? CODE_BAD : sextet_of(char_code);
	assign is_junk = ((code | JUNK_MASK) == JUNK_CODE);
	assign word    = {hold_q, code[5:0]};

	// Next string state and the bytes this character releases.
	always_comb begin
		lead_n = lead_q;
		gp_n   = gp_q;
		hold_n = hold_q;
		pad_n  = pad_q;
		err_n  = err_q | char_code[7];
		kc_n   = kc_q;
		ka_n   = ka_q;
		hj_n   = hj_q;
		hja_n  = hja_q;
		nb     = 2'd0;
		bytes  = '0;
		if (!(lead_q && code == CODE_WS)) begin
			lead_n = 1'b0;
			if (is_junk) begin
				hj_n  = hj_q + 2'd1;
				hja_n = 1'b1;
			end else begin
				if (hja_q && !pad_q) err_n = 1'b1;
				kc_n  = kc_q + hj_q + 2'd1;
				ka_n  = 1'b1;
				hj_n  = 2'd0;
				hja_n = 1'b0;
				if (!pad_q) begin
					if (char_code == CHAR_PAD) begin
						if (gp_q < 2'd2) begin
							err_n = 1'b1;
						end else if (gp_q == 2'd2) begin
							nb       = 2'd1;
							bytes[0] = hold_q[11:4];
						end else begin
							nb       = 2'd2;
							bytes[0] = hold_q[17:10];
							bytes[1] = hold_q[9:2];
						end
						pad_n = 1'b1;
					end else if (code[7]) begin
						err_n = 1'b1;
					end else if (gp_q == 2'd3) begin
						nb       = 2'd3;
						bytes[0] = word[23:16];
						bytes[1] = word[15:8];
						bytes[2] = word[7:0];
						gp_n     = 2'd0;
						hold_n   = '0;
					end else begin
						hold_n = {hold_q[11:0], code[5:0]};
						gp_n   = gp_q + 2'd1;
					end
				end
			end
		end
		// Once an error is known no further bytes leave the block.
		if (err_n) nb = 2'd0;
	end

	// Saturating byte count.
	always_comb begin
		sum = {2'b00, cnt_q} + {{COUNT_BITS{1'b0}}, nb};
		if (sum > {2'b00, {COUNT_BITS{1'b1}}}) cnt_n = {COUNT_BITS{1'b1}};
		else cnt_n = sum[COUNT_BITS-1:0];
	end

	// Final status of the string.
	assign bad = err_n || (kc_n != 2'd0) || (!ka_n && hja_n);

	// Queue entry for this item.
	always_comb begin
		entry.bytes  = bytes;
		entry.nbytes = nb;
		entry.fin    = final_char;
		entry.bad    = final_char & bad;
		entry.total  = (final_char && !bad) ? TOTAL_W'(cnt_n) : '0;
		push         = accept && (nb != 2'd0 || final_char);
	end

	// String state; the last item returns everything to its start value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= 1'b1;
			gp_q   <= '0;
			hold_q <= '0;
			pad_q  <= 1'b0;
			err_q  <= 1'b0;
			kc_q   <= '0;
			ka_q   <= 1'b0;
			hj_q   <= '0;
			hja_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (accept) begin
			if (final_char) begin
				lead_q <= 1'b1;
				gp_q   <= '0;
				hold_q <= '0;
				pad_q  <= 1'b0;
				err_q  <= 1'b0;
				kc_q   <= '0;
				ka_q   <= 1'b0;
				hj_q   <= '0;
				hja_q  <= 1'b0;
				cnt_q  <= '0;
			end else begin
				lead_q <= lead_n;
				gp_q   <= gp_n;
				hold_q <= hold_n;
				pad_q  <= pad_n;
				err_q  <= err_n;
				kc_q   <= kc_n;
				ka_q   <= ka_n;
				hj_q   <= hj_n;
				hja_q  <= hja_n;
				cnt_q  <= cnt_n;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/b64d_queue.sv =====
// Short queue of result entries between the front and back parts.
`default_nettype none

module b64d_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire b64d_pkg::b64d_entry_t wr_entry,
	input  wire logic              pop,
	output logic                   full,
	output logic                   not_empty,
	output b64d_pkg::b64d_entry_t  head
);
	import b64d_pkg::*;

	b64d_entry_t     slots_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_CW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full      = (count_q == Q_CW'(Q_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = slots_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) slots_q[wr_ptr_q] <= wr_entry;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			if (do_push && !do_pop) count_q <= count_q + Q_CW'(1);
			else if (!do_push && do_pop) count_q <= count_q - Q_CW'(1);
		end
	end

endmodule

`default_nettype wire

// ===== design/b64d_back.sv =====
// Back part: splits each queue entry into result items and holds them in the output register.
`default_nettype none

module b64d_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              head_valid,
	input  wire b64d_pkg::b64d_entry_t head,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [7:0]             out_byte,
	output logic                   byte_valid,
	output logic                   end_of_run,
	output logic                   bad_data,
	output logic [b64d_pkg::TOTAL_W-1:0] bytes_total
);
	import b64d_pkg::*;

	logic [1:0]         idx_q;
	logic               valid_q;
	logic [7:0]         byte_q;
	logic               bvalid_q;
	logic               last_q;
	logic               bad_q;
	logic [TOTAL_W-1:0] total_q;

	logic [1:0]         nres;
	logic               load;
	logic               at_last;
	logic [7:0]         sel_byte;

	// Result count of the head entry: an end with no byte still gives one item.
	assign nres    = (head.nbytes == 2'd0) ? 2'd1 : head.nbytes;
	assign load    = head_valid && (!valid_q || out_ready);
	assign at_last = (idx_q == nres - 2'd1);
	assign pop     = load && at_last;

	// Byte of the head entry at the current position.
	always_comb begin
		case (idx_q)
			2'd0:    sel_byte = head.bytes[0];
			2'd1:    sel_byte = head.bytes[1];
			2'd2:    sel_byte = head.bytes[2];
			default: sel_byte = '0;
		endcase
	end

	// Position within the head entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (load) begin
			idx_q <= at_last ? 2'd0 : idx_q + 2'd1;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Output register payload; status fields ride only on the closing item.
	always_ff @(posedge clk) begin
		if (load) begin
			bvalid_q <= (head.nbytes != 2'd0);
			byte_q   <= (head.nbytes != 2'd0) ? sel_byte : 8'd0;
			last_q   <= head.fin && at_last;
			bad_q    <= head.fin && at_last && head.bad;
			total_q  <= (head.fin && at_last) ? head.total : '0;
		end
	end

	assign out_valid   = valid_q;
	assign out_byte    = byte_q;
	assign byte_valid  = bvalid_q;
	assign end_of_run  = last_q;
	assign bad_data    = bad_q;
	assign bytes_total = total_q;

endmodule

`default_nettype wire

// ===== design/base64_stream_decoder_top.sv =====
// Top level of the base64 stream decoder.
//
// The s_axis channel takes one character per item in s_axis_tdata, with
// s_axis_tlast on the last character of the encoded string. The m_axis
// channel gives one result item per decoded byte: out_byte in tdata bits
// 7:0, the status bit in bit 8 and the byte count in bits 32:9, tuser set
// when the byte is real, tlast on the item that closes the string. When
// the string ends without a byte, one item with tuser low closes it.
// The front part takes one character per cycle while the queue is not
// full and writes any entry it forms into the queue at the accepting
// edge; the back part loads the output register from the queue head
// when that register is empty or taken. The back part sends one result
// item per cycle while the receiver is ready, so a full group of four
// characters releases three bytes as three items; a four-entry queue
// absorbs this, and s_axis_tready drops only when that queue is full.
// Sustained input is one character per cycle for valid base64 text
// while the receiver is ready. Reset clears the string state and the
// queue and empties the output register. When the receiver stalls, the
// output item holds and the queue fills; input stalls when it is full.
`default_nettype none

module base64_stream_decoder_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
	input  wire logic        s_axis_tlast,   // final_char
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,   // [7:0] out_byte, [8] bad_data,
	                                         // [32:9] bytes_total, [39:33] zero
	output logic             m_axis_tuser,   // byte_valid
	output logic             m_axis_tlast    // end_of_run
);
	import b64d_pkg::*;

	logic               accept;
	logic               push;
	logic               pop;
	logic               full;
	logic               not_empty;
	b64d_entry_t        wr_entry;
	b64d_entry_t        head;
	logic [7:0]         out_byte;
	logic               bad_data;
	logic [TOTAL_W-1:0] bytes_total;

	assign s_axis_tready = !full;
	assign accept        = s_axis_tvalid && !full;

	b64d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.char_code  (s_axis_tdata),
		.final_char (s_axis_tlast),
		.push       (push),
		.entry      (wr_entry)
	);

	b64d_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_entry  (wr_entry),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.head      (head)
	);

	b64d_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (not_empty),
		.head        (head),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_byte    (out_byte),
		.byte_valid  (m_axis_tuser),
		.end_of_run  (m_axis_tlast),
		.bad_data    (bad_data),
		.bytes_total (bytes_total)
	);

	// Output item packing.
	assign m_axis_tdata = {7'd0, bytes_total, bad_data, out_byte};

endmodule

`default_nettype wire

// ===== design/b64d_checker.sv =====
// Port-level checks of the base64 stream decoder and their binding to the top level.
`default_nettype none

module b64d_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [39:0] m_axis_tdata,
	input wire logic        m_axis_tuser,
	input wire logic        m_axis_tlast
);

	// A stalled output item stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output item dropped while stalled");

	// Status and count appear only on the item that closes the string.
	a_status_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[32:8] == 25'd0)
		else $error("status or count on an item before the end");

	// A failed string reports no byte count.
	a_bad_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast && m_axis_tdata[8] |-> m_axis_tdata[32:9] == 24'd0)
		else $error("byte count given with a data error");

	// An item without a byte only closes a string and carries a zero byte.
	a_empty_item: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && m_axis_tdata[7:0] == 8'd0)
		else $error("item without a byte that does not close the string");

endmodule

bind base64_stream_decoder_top b64d_checker u_b64d_checker (.*);

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the base64 stream decoder with its own decode predictor.
`default_nettype none

module tb_top;
	import b64d_pkg::*;

	localparam int LIMIT_CYCLES = 300000;
	localparam int DRAIN_TAIL   = 20;
	localparam int RANDOM_CHARS = 100;

	// One decoder result item as the predictor expects it.
	typedef struct {
		logic [7:0]         data;
		logic               real_byte;
		logic               closes;
		logic               bad;
		logic [TOTAL_W-1:0] total;
	} dec_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;  // [7:0] char_code
	logic        s_axis_tlast = 1'b0;   // final_char
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;          // [7:0] out_byte, [8] bad_data, [32:9] bytes_total
	logic        m_axis_tuser;          // byte_valid
	logic        m_axis_tlast;          // end_of_run

	// Predictor copy of the string state.
	logic                  lead_blank;
	logic [1:0]            grp_pos;
	logic [17:0]           hold_bits;
	logic                  pad_seen;
	logic                  err_flag;
	logic [1:0]            kept_mod4;
	logic                  kept_seen;
	logic [1:0]            junk_mod4;
	logic                  junk_seen;
	logic [COUNT_BITS-1:0] decoded_count;

	dec_result_t decoded_q[$];
	int          err_count = 0;
	int          chars_sent = 0;
	int          cycles = 0;
	bit          no_idle = 1'b0;
	int          stall_left = 0;

	base64_stream_decoder_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #10 clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("TIMEOUT after %0d cycles, %0d results outstanding", cycles, decoded_q.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH cycle %0d %s: got %0h expected %0h", cycles, what, got, want);
		err_count++;
	endtask

	// Returns a sextet value, a blank or junk class, or the invalid code.
	function automatic logic [7:0] char_class(input logic [7:0] c);
		if (c[7])
			return CODE_BAD;
		if (c >= "A" && c <= "Z")
			return c - "A";
		if (c >= "a" && c <= "z")
			return c - "a" + 8'd26;
		if (c >= "0" && c <= "9")
			return c - "0" + 8'd52;
		case (c)
			"+":          return CODE_PLUS;
			"/":          return CODE_SLSH;
			8'h09, 8'h20: return CODE_WS;
			8'h0A:        return CODE_LF;
			8'h0D:        return CODE_CR;
			"-":          return CODE_DASH;
			default:      return CODE_BAD;
		endcase
	endfunction

	function automatic void clear_string_state();
		lead_blank    = 1'b1;
		grp_pos       = 2'd0;
		hold_bits     = '0;
		pad_seen      = 1'b0;
		err_flag      = 1'b0;
		kept_mod4     = 2'd0;
		kept_seen     = 1'b0;
		junk_mod4     = 2'd0;
		junk_seen     = 1'b0;
		decoded_count = '0;
	endfunction

	// A decoded byte is expected only while the string is still clean.
	function automatic void push_byte(input logic [7:0] b);
		dec_result_t r;
		if (err_flag)
			return;
		r.data      = b;
		r.real_byte = 1'b1;
		r.closes    = 1'b0;
		r.bad       = 1'b0;
		r.total     = '0;
		decoded_q.push_back(r);
		if (decoded_count != {COUNT_BITS{1'b1}})
			decoded_count = decoded_count + 1'b1;
	endfunction

	// Predicts the result items caused by one accepted character.
	function automatic void decode_char(input logic [7:0] c, input logic fin);
		logic [7:0]  cls;
		logic [23:0] word;
		logic        bad;
		int          prior_cnt;
		dec_result_t r;
		prior_cnt = decoded_q.size();
		cls = char_class(c);
		if (c[7])
			err_flag = 1'b1;
		if (!(lead_blank && cls == CODE_WS)) begin
			lead_blank = 1'b0;
			if ((cls | JUNK_MASK) == JUNK_CODE) begin
				junk_mod4 = junk_mod4 + 2'd1;
				junk_seen = 1'b1;
			end else begin
				// Held junk in front of a kept character is an error before padding.
				if (junk_seen && !pad_seen)
					err_flag = 1'b1;
				kept_mod4 = kept_mod4 + junk_mod4 + 2'd1;
				kept_seen = 1'b1;
				junk_mod4 = 2'd0;
				junk_seen = 1'b0;
				if (!pad_seen) begin
					if (c == CHAR_PAD) begin
						if (grp_pos < 2'd2) begin
							err_flag = 1'b1;
						end else if (grp_pos == 2'd2) begin
							push_byte(hold_bits[11:4]);
						end else begin
							push_byte(hold_bits[17:10]);
							push_byte(hold_bits[9:2]);
						end
						pad_seen = 1'b1;
					end else if (cls[7]) begin
						err_flag = 1'b1;
					end else if (grp_pos == 2'd3) begin
						word = {hold_bits, cls[5:0]};
						push_byte(word[23:16]);
						push_byte(word[15:8]);
						push_byte(word[7:0]);
						grp_pos   = 2'd0;
						hold_bits = '0;
					end else begin
						hold_bits = {hold_bits[11:0], cls[5:0]};
						grp_pos   = grp_pos + 2'd1;
					end
				end
			end
		end
		// The last character closes the string on its last result item.
		if (fin) begin
			bad = err_flag || kept_mod4 != 2'd0 || (!kept_seen && junk_seen);
			if (decoded_q.size() == prior_cnt) begin
				r.data      = 8'h00;
				r.real_byte = 1'b0;
				r.closes    = 1'b0;
				r.bad       = 1'b0;
				r.total     = '0;
				decoded_q.push_back(r);
			end
			r = decoded_q.pop_back();
			r.closes = 1'b1;
			r.bad    = bad;
			r.total  = bad ? '0 : decoded_count[TOTAL_W-1:0];
			decoded_q.push_back(r);
			clear_string_state();
		end
	endfunction

	// Result checker: each accepted result against the oldest expectation.
	always @(posedge clk) begin : check_results
		dec_result_t w;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (decoded_q.size() == 0) begin
				report_mismatch("unexpected result item", m_axis_tdata, 0);
			end else begin
				w = decoded_q.pop_front();
				if (m_axis_tdata[7:0] !== w.data)
					report_mismatch("out_byte", m_axis_tdata[7:0], w.data);
				if (m_axis_tuser !== w.real_byte)
					report_mismatch("byte_valid", m_axis_tuser, w.real_byte);
				if (m_axis_tlast !== w.closes)
					report_mismatch("end_of_run", m_axis_tlast, w.closes);
				if (m_axis_tdata[8] !== w.bad)
					report_mismatch("bad_data", m_axis_tdata[8], w.bad);
				if (m_axis_tdata[32:9] !== w.total)
					report_mismatch("bytes_total", m_axis_tdata[32:9], w.total);
				if (m_axis_tdata[39:33] !== 7'd0)
					report_mismatch("tdata fill bits", m_axis_tdata[39:33], 0);
			end
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(5, 30);
		return $urandom_range(1, 3);
	endfunction

	// Receiver side: random stalls unless a no-idle stretch is running.
	always @(posedge clk) begin
		if (no_idle) begin
			stall_left = 0;
			m_axis_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 99) < 25) begin
			stall_left = gap_len() - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Presents one character and returns at the edge where it is accepted.
	task automatic send_char(input logic [7:0] c, input logic fin);
		int gap;
		gap = (!no_idle && $urandom_range(0, 99) < 30) ? gap_len() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= fin;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		decode_char(c, fin);
		chars_sent++;
	endtask

	// Sends a whole string, the last character flagged.
	task automatic send_seq(input logic [7:0] text[$]);
		for (int i = 0; i < text.size(); i++)
			send_char(text[i], i == text.size() - 1);
	endtask

	task automatic send_text(input string s);
		logic [7:0] text[$];
		for (int i = 0; i < s.len(); i++)
			text.push_back(s[i]);
		send_seq(text);
	endtask

	// Drops valid and holds off until every expected result has arrived.
	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (decoded_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] b64_char(input int idx);
		if (idx < 26)
			return 8'(idx) + "A";
		if (idx < 52)
			return 8'(idx - 26) + "a";
		if (idx < 62)
			return 8'(idx - 52) + "0";
		return (idx == 62) ? "+" : "/";
	endfunction

	function automatic logic [7:0] junk_char();
		case ($urandom_range(0, 4))
			0:       return 8'h09;
			1:       return 8'h0A;
			2:       return 8'h0D;
			3:       return "-";
			default: return 8'h20;
		endcase
	endfunction

	// Well-formed text: optional leading blanks, groups, padding, trailing junk.
	function automatic void build_clean_text(ref logic [7:0] text[$]);
		int lead;
		int groups;
		int pads;
		int tail;
		text.delete();
		lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
		for (int i = 0; i < lead; i++)
			text.push_back($urandom_range(0, 1) ? 8'h20 : 8'h09);
		groups = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 2) : $urandom_range(0, 4);
		pads = $urandom_range(0, 2);
		for (int g = 0; g < groups; g++) begin
			for (int k = 0; k < 4; k++) begin
				if (g == groups - 1 && k >= 4 - pads)
					text.push_back(CHAR_PAD);
				else
					text.push_back(b64_char($urandom_range(0, 63)));
			end
		end
		tail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		for (int i = 0; i < tail; i++)
			text.push_back(junk_char());
		if (text.size() == 0)
			text.push_back(8'h20);
	endfunction

	// One random defect: a stray byte, a lost character, junk or padding inserted.
	function automatic void break_text(ref logic [7:0] text[$]);
		int pos;
		pos = $urandom_range(0, text.size() - 1);
		case ($urandom_range(0, 3))
			0: text[pos] = 8'($urandom_range(0, 255));
			1: if (text.size() > 1) text.delete(pos);
			2: text.insert(pos, junk_char());
			default: text.insert(pos, CHAR_PAD);
		endcase
	endfunction

	function automatic void noise_text(ref logic [7:0] text[$]);
		int len;
		text.delete();
		len = $urandom_range(1, 6);
		for (int i = 0; i < len; i++)
			text.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 255)) :
				8'($urandom_range(0, 127)));
	endfunction

	task automatic test_directed();
		send_text(" +/9z");         // leading blank, both symbol characters, full group
		send_text("TWE=\015");      // padding in the last position, trailing CR dropped
		send_text("TQ==");          // double padding, second pad only counted
		send_text("A\tz0");         // blank between data characters
		send_text("A=");            // padding too early, short length
		send_char(8'hFF, 1'b1);     // top of the character range
		send_char(8'h00, 1'b1);     // bottom of the range, invalid
		send_char(8'h80, 1'b1);     // first non-ASCII code
		send_text(" \n");           // nothing but junk after the leading blank
		send_text(" ");             // empty string
	endtask

	// The sender holds off between strings until everything has come out.
	task automatic test_pause_drain();
		logic [7:0] text[$];
		for (int i = 0; i < 3; i++) begin
			build_clean_text(text);
			send_seq(text);
			wait_drain();
		end
	endtask

	// Full rate on both sides for a few strings.
	task automatic test_back_to_back();
		logic [7:0] text[$];
		no_idle = 1'b1;
		for (int i = 0; i < 3; i++) begin
			build_clean_text(text);
			send_seq(text);
		end
		no_idle = 1'b0;
	endtask

	task automatic test_random();
		logic [7:0] text[$];
		int         stop_at;
		int         kind;
		stop_at = chars_sent + RANDOM_CHARS;
		while (chars_sent < stop_at) begin
			no_idle = ($urandom_range(0, 6) == 0);
			kind = $urandom_range(0, 9);
			build_clean_text(text);
			if (kind == 7 || kind == 8)
				break_text(text);
			else if (kind == 9)
				noise_text(text);
			send_seq(text);
			if ($urandom_range(0, 9) == 0)
				wait_drain();
		end
		no_idle = 1'b0;
	endtask

	initial begin
		clear_string_state();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_pause_drain();
		test_back_to_back();
		test_random();

		wait_drain();
		repeat (DRAIN_TAIL) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
design/b64d_pkg.sv
design/b64d_front.sv
design/b64d_queue.sv
design/b64d_back.sv
design/base64_stream_decoder_top.sv
design/b64d_checker.sv
dv/tb_top.sv
